// ===== design/cursor_line_edit_buffer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the line edit buffer
// Clocked property wrappers, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_ASSERT_SVH

// property checked only while out of reset
`define CLEB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CLEB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cleb_pkg.sv =====
// ---------------------------------------------------------------------------
// cleb_pkg
// Command and status codes, field widths and the controller command struct.
// ---------------------------------------------------------------------------
package cleb_pkg;

	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 10;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 11;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BKSP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic load;    // item accepted: latch fields, issue store read
		logic commit;  // update store and counts, load result register
	} ctrl_t;

endpackage

// ===== design/cleb_ctrl.sv =====
// ---------------------------------------------------------------------------
// cleb_ctrl
// Two-state sequencer: accept and read, then commit into the result register.
// ---------------------------------------------------------------------------
module cleb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output logic            res_valid,
	input  logic            res_ready,
	output cleb_pkg::ctrl_t ctrl
);
	import cleb_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic commit;

	assign cmd_ready   = (state_q == S_IDLE);
	// commit only once the result register is free or being emptied
	assign commit      = (state_q == S_EXEC) && (!out_valid_q || res_ready);
	assign ctrl.load   = cmd_valid && cmd_ready;
	assign ctrl.commit = commit;
	assign res_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.load)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/cleb_dp.sv =====
// ---------------------------------------------------------------------------
// cleb_dp
// Gap buffer datapath: text store, front/back counts and result register.
// ---------------------------------------------------------------------------
module cleb_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cleb_pkg::ctrl_t              ctrl,
	input  logic [cleb_pkg::CMD_W-1:0]   cmd,
	input  logic [cleb_pkg::CHAR_W-1:0]  char_in,
	input  logic [cleb_pkg::IDX_W-1:0]   read_index,
	output logic [cleb_pkg::STAT_W-1:0]  status,
	output logic [cleb_pkg::CHAR_W-1:0]  char_out,
	output logic [cleb_pkg::LEN_W-1:0]   text_length,
	output logic [cleb_pkg::LEN_W-1:0]   cursor_pos
);
	import cleb_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int IW    = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
	localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic [CHAR_W-1:0] text_store_q [CAPACITY];
	logic [CHAR_W-1:0] rd_data_q;

	logic [CNT_W-1:0]  front_q, back_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] char_in_q;
	logic [IDX_W-1:0]  idx_q;

	logic [STAT_W-1:0] status_q;
	logic [CHAR_W-1:0] char_out_q;
	logic [LEN_W-1:0]  text_length_q, cursor_pos_q;

	logic [CNT_W-1:0]  len, back_cap, front_dec;
	logic [IW-1:0]     len_w, front_w, idx_in_w, idx_q_w;
	logic [AW-1:0]     rd_addr;

	logic              we;
	logic [AW-1:0]     wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic [STAT_W-1:0] status_n;
	logic [CHAR_W-1:0] char_n;
	logic [CNT_W-1:0]  front_n, back_n, len_n;
	logic [EXT_W-1:0]  len_ext, front_ext;

	assign len       = front_q + back_q;
	assign back_cap  = CAP_C - back_q;
	assign front_dec = front_q - CNT_W'(1);
	assign len_w     = IW'(len);
	assign front_w   = IW'(front_q);
	assign idx_in_w  = IW'(read_index);
	assign idx_q_w   = IW'(idx_q);

	// read address for the item being accepted
	always_comb begin
		case (cmd)
			CMD_LEFT:  rd_addr = AW'(front_dec);
			CMD_RIGHT: rd_addr = AW'(back_cap);
			CMD_READ: begin
				if (idx_in_w < front_w)
					rd_addr = AW'(idx_in_w);
				else
					rd_addr = AW'(IW'(CAP_C) - len_w + idx_in_w);
			end
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		status_n = ST_DONE;
		char_n   = '0;
		front_n  = front_q;
		back_n   = back_q;
		we       = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_data_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (len == CAP_C) begin
					status_n = ST_FULL;
				end else begin
					we      = 1'b1;
					wr_addr = AW'(front_q);
					wr_data = char_in_q;
					front_n = front_q + CNT_W'(1);
				end
			end
			CMD_LEFT: begin
				if (front_q == '0) begin
					status_n = ST_IGNORED;
				end else begin
					// character before the cursor moves to the bottom of the back part
					we      = 1'b1;
					wr_addr = AW'(back_cap - CNT_W'(1));
					front_n = front_dec;
					back_n  = back_q + CNT_W'(1);
				end
			end
			CMD_RIGHT: begin
				if (back_q == '0) begin
					status_n = ST_IGNORED;
				end else begin
					we      = 1'b1;
					wr_addr = AW'(front_q);
					front_n = front_q + CNT_W'(1);
					back_n  = back_q - CNT_W'(1);
				end
			end
			CMD_BKSP: begin
				if (front_q == '0)
					status_n = ST_IGNORED;
				else
					front_n = front_dec;
			end
			CMD_READ: begin
				if (idx_q_w >= len_w)
					status_n = ST_RANGE;
				else
					char_n = rd_data_q;
			end
			default: status_n = ST_IGNORED;
		endcase
	end

	assign len_n     = front_n + back_n;
	assign len_ext   = EXT_W'(len_n);
	assign front_ext = EXT_W'(front_n);

	always_ff @(posedge clk) begin
		if (ctrl.load)
			rd_data_q <= text_store_q[rd_addr];
		if (ctrl.commit && we)
			text_store_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= cmd;
			char_in_q <= char_in;
			idx_q     <= read_index;
		end
		if (ctrl.commit) begin
			status_q      <= status_n;
			char_out_q    <= char_n;
			text_length_q <= len_ext[LEN_W-1:0];
			cursor_pos_q  <= front_ext[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
		end else if (ctrl.commit) begin
			front_q <= front_n;
			back_q  <= back_n;
		end
	end

	assign status      = status_q;
	assign char_out    = char_out_q;
	assign text_length = text_length_q;
	assign cursor_pos  = cursor_pos_q;

endmodule

// ===== design/cursor_line_edit_buffer.sv =====
// ---------------------------------------------------------------------------
// cursor_line_edit_buffer
// Gap buffer line editor with cursor; one result item per command item.
// ---------------------------------------------------------------------------
// For each item the text store is read in the cycle it is accepted (the
// character to shift across the gap, or the one to be read); once the
// output register is free or being emptied, the store is written, the
// counts updated and the result loaded into the output register (the store
// read is synchronous). A result may wait in the output register while the
// next item is accepted; that item then completes once the result is taken.
// Reset clears the front and back counts and the control state at once; the
// store needs no clearing pass, as data read from unwritten places is unused.
module cursor_line_edit_buffer #(
	parameter int CAPACITY = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [cleb_pkg::CMD_W-1:0]   cmd,
	input  logic [cleb_pkg::CHAR_W-1:0]  char_in,
	input  logic [cleb_pkg::IDX_W-1:0]   read_index,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [cleb_pkg::STAT_W-1:0]  status,
	output logic [cleb_pkg::CHAR_W-1:0]  char_out,
	output logic [cleb_pkg::LEN_W-1:0]   text_length,
	output logic [cleb_pkg::LEN_W-1:0]   cursor_pos
);
	import cleb_pkg::*;

	ctrl_t ctrl;

	cleb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctrl      (ctrl)
	);

	cleb_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cmd         (cmd),
		.char_in     (char_in),
		.read_index  (read_index),
		.status      (status),
		.char_out    (char_out),
		.text_length (text_length),
		.cursor_pos  (cursor_pos)
	);

endmodule

// ===== design/cleb_checker.sv =====
// ---------------------------------------------------------------------------
// cleb_checker
// Port-level checks on the line edit buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "cursor_line_edit_buffer_assert.svh"

module cleb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic [cleb_pkg::CMD_W-1:0]   cmd,
	input logic [cleb_pkg::CHAR_W-1:0]  char_in,
	input logic [cleb_pkg::IDX_W-1:0]   read_index,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [cleb_pkg::STAT_W-1:0]  status,
	input logic [cleb_pkg::CHAR_W-1:0]  char_out,
	input logic [cleb_pkg::LEN_W-1:0]   text_length,
	input logic [cleb_pkg::LEN_W-1:0]   cursor_pos
);
	import cleb_pkg::*;

	logic [STAT_W+CHAR_W+2*LEN_W-1:0] res_fields;

	assign res_fields = {status, char_out, text_length, cursor_pos};

	// one item in flight: no accept in the cycle right after an accept
	`CLEB_ASSERT(a_one_in_flight, (cmd_valid && cmd_ready) |=> !cmd_ready, "accept after accept")
	// only a successful read returns a character
	`CLEB_ASSERT(a_char_zero, (res_valid && status != ST_DONE) |-> char_out == '0, "char on fail")
	`CLEB_ASSERT(a_res_hold, (res_valid && !res_ready) |=> res_valid, "result dropped")
	`CLEB_ASSERT(a_res_stable, (res_valid && !res_ready) |=> $stable(res_fields), "result changed")

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (.*);
